@@ design/oaht_pkg.sv @@
// Shared types and constants for the open-addressing hash table.
// Holds the payload word structs, status and command codes, and register map.
// No dependencies.
`default_nettype none

package oaht_pkg;

    localparam int CAPACITY_DEF = 1024;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 64;
    localparam int COUNT_W = 11;
    localparam int LIMIT_W = 10;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd768;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_LOAD_LIMIT = 1'b0;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_SET = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_ZERO_KEY = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] read_value;
        logic [1:0]         status;
        logic [COUNT_W-1:0] entry_count;
    } t_out_word;

endpackage

`default_nettype wire

@@ design/oaht_ram.sv @@
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Used for the key store and the value store. No dependencies.
`default_nettype none

module oaht_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output      logic [DATA_W-1:0] o_rdata
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/open_addressing_hash_table.sv @@
// Open-addressing hash table, top level: probe sequencer, count and APB register.
// Depends on oaht_pkg and oaht_ram.
// Flow: after accept, each probed slot is read from the key store; a get hit adds a value read.
// One word at a time: no new word is accepted until the result of the last one is loaded.
// Reset: synchronous; the key store is then cleared slot by slot with stall high.
// The count, the load limit and both channels' control return to their reset values.
`default_nettype none

module open_addressing_hash_table
    import oaht_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output      logic                  o_in_stall,
    input  wire t_in_word              i_in_word,
    output      logic                  o_out_valid,
    input  wire logic                  i_out_stall,
    output      t_out_word             o_out_word,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output      logic [APB_DATA_W-1:0] prdata,
    output      logic                  pready
);

    localparam int IW = $clog2(CAPACITY);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_PROBE  = 5'b00100,
        S_VREAD  = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic               r_cmd;
    logic [KEY_W-1:0]   r_key;
    logic [VALUE_W-1:0] r_value;
    logic [IW-1:0]      r_slot, n_slot;
    logic [IW-1:0]      r_probes, n_probes;
    logic [IW-1:0]      r_clr_idx;
    logic               r_found, n_found;
    logic [VALUE_W-1:0] r_rdval, n_rdval;
    logic [1:0]         r_status, n_status;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [LIMIT_W-1:0] r_load_limit;
    logic               r_out_valid;
    t_out_word          r_out_word;

    logic               key_we, key_re, val_we, val_re;
    logic [IW-1:0]      key_waddr, key_raddr;
    logic [KEY_W-1:0]   key_wdata, key_rdata;
    logic [VALUE_W-1:0] val_rdata;
    logic [IW-1:0]      slot_next;
    logic               in_accept, out_take, out_load, cfg_write;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_take  = r_out_valid && !i_out_stall;
    assign out_load  = (r_state == S_RESULT) && (!r_out_valid || !i_out_stall);
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_LOAD_LIMIT);
    assign slot_next = (r_slot << 2) + r_slot + IW'(1);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_LOAD_LIMIT) ?
                         APB_DATA_W'(r_load_limit) : '0;

    always_comb begin
        n_state   = r_state;
        n_slot    = r_slot;
        n_probes  = r_probes;
        n_found   = r_found;
        n_rdval   = r_rdval;
        n_status  = r_status;
        n_count   = r_count;
        key_we    = 1'b0;
        key_waddr = r_slot;
        key_wdata = r_key;
        key_re    = 1'b0;
        key_raddr = r_slot;
        val_we    = 1'b0;
        val_re    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                key_we    = 1'b1;
                key_waddr = r_clr_idx;
                key_wdata = '0;
                if (&r_clr_idx) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_found  = 1'b0;
                    n_rdval  = '0;
                    n_probes = '0;
                    n_slot   = i_in_word.key[IW-1:0];
                    if (i_in_word.key == '0) begin
                        n_status = STATUS_ZERO_KEY;
                        n_state  = S_RESULT;
                    end else begin
                        n_status  = STATUS_OK;
                        key_re    = 1'b1;
                        key_raddr = i_in_word.key[IW-1:0];
                        n_state   = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (key_rdata == r_key) begin
                    n_found = 1'b1;
                    if (r_cmd == CMD_GET) begin
                        val_re  = 1'b1;
                        n_state = S_VREAD;
                    end else begin
                        val_we  = 1'b1;
                        n_state = S_RESULT;
                    end
                end else if (key_rdata == '0) begin
                    if (r_cmd == CMD_SET) begin
                        if (r_count >= COUNT_W'(r_load_limit)) begin
                            n_status = STATUS_FULL;
                        end else begin
                            key_we  = 1'b1;
                            val_we  = 1'b1;
                            n_count = r_count + COUNT_W'(1);
                        end
                    end
                    n_state = S_RESULT;
                end else if (&r_probes) begin
                    if (r_cmd == CMD_SET) begin
                        n_status = STATUS_FULL;
                    end
                    n_state = S_RESULT;
                end else begin
                    n_probes  = r_probes + IW'(1);
                    n_slot    = slot_next;
                    key_re    = 1'b1;
                    key_raddr = slot_next;
                end
            end
            S_VREAD: begin
                n_rdval = val_rdata;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_idx    <= '0;
            r_count      <= '0;
            r_load_limit <= LIMIT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + IW'(1);
            end
            if (cfg_write) begin
                r_load_limit <= pwdata[LIMIT_W-1:0];
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd   <= i_in_word.cmd;
            r_key   <= i_in_word.key;
            r_value <= i_in_word.value;
        end
        r_slot   <= n_slot;
        r_probes <= n_probes;
        r_found  <= n_found;
        r_rdval  <= n_rdval;
        r_status <= n_status;
        if (out_load) begin
            r_out_word <= '{found: r_found, read_value: r_rdval,
                            status: r_status, entry_count: r_count};
        end
    end

    oaht_ram #(
        .ADDR_W (IW),
        .DATA_W (KEY_W)
    ) u_key_store (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_re    (key_re),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    oaht_ram #(
        .ADDR_W (IW),
        .DATA_W (VALUE_W)
    ) u_value_store (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (r_slot),
        .i_wdata (r_value),
        .i_re    (val_re),
        .i_raddr (r_slot),
        .o_rdata (val_rdata)
    );

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_out_valid)
        else $error("Result word presented during key store clear.");

    a_count_steps_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(!i_rst_n) |->
        ((r_count == $past(r_count)) || (r_count == COUNT_W'($past(r_count) + 1'b1))))
        else $error("Entry count changed by more than one.");

    a_insert_nonzero_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (key_we && (r_state != S_CLEAR)) |-> (r_key != '0))
        else $error("Zero key written into the key store.");

    a_accept_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> ((r_state == S_PROBE) || (r_state == S_RESULT)))
        else $error("Accepted word did not start a probe or a result.");

endmodule

`default_nettype wire
